@@ rtl/core/mlfp_pkg.sv @@
package mlfp_pkg;

    localparam int BYTE_W         = 8;
    localparam int LEN_W          = 16;
    localparam int CNT_W          = 3;
    localparam int HDR_BYTES      = 5;
    localparam int FRAME_HDR_SIZE = 6;

    // controller to datapath
    typedef struct packed {
        logic hdr_clr;   // magic seen, restart header collection
        logic hdr_wr;    // store incoming header word
        logic hdr_done;  // fifth header word taken, latch length info
        logic rp_step;   // one resync replay step
        logic emit;      // push one stored header word to the output
        logic cont_out;  // push the incoming content word to the output
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic magic_hit;
        logic hdr_full;
        logic len_short;
        logic hdr_only;
        logic rp_match;
        logic step_last;
        logic rem_zero;
        logic rem_one;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/core/mlfp_dpath.sv @@
module mlfp_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [mlfp_pkg::BYTE_W-1:0]   i_cfg_data,
    input  logic [mlfp_pkg::BYTE_W-1:0]   i_byte,
    input  mlfp_pkg::t_cmd                i_cmd,
    output mlfp_pkg::t_sts                o_sts,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mlfp_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                          o_out_first,
    output logic                          o_out_last,
    output logic                          o_out_run_last
);
    import mlfp_pkg::*;

    logic [BYTE_W-1:0] r_magic;
    logic [BYTE_W-1:0] r_store [HDR_BYTES];
    logic [CNT_W-1:0]  r_hdr_cnt;
    logic [CNT_W-1:0]  r_step;
    logic [LEN_W-1:0]  r_rem;
    logic              r_hdr_only;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_first;
    logic              r_out_last;
    logic              r_out_run_last;

    logic [LEN_W-1:0]  w_len;
    logic              w_out_free;

    // length field is big-endian: high byte stored, low byte arriving now
    assign w_len      = {r_store[3], i_byte};
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts           = '0;
        o_sts.magic_hit = (i_byte == r_magic);
        o_sts.hdr_full  = (r_hdr_cnt == CNT_W'(HDR_BYTES - 1));
        o_sts.len_short = (w_len < LEN_W'(FRAME_HDR_SIZE));
        o_sts.hdr_only  = r_hdr_only;
        o_sts.rp_match  = (r_store[0] == r_magic);
        o_sts.step_last = (r_step == CNT_W'(1));
        o_sts.rem_zero  = (r_rem == '0);
        o_sts.rem_one   = (r_rem == LEN_W'(1));
        o_sts.out_free  = w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= '0;
        end else if (i_cfg_valid) begin
            r_magic <= i_cfg_data;
        end
    end

    // header store: one write port, reads only at fixed slots, shifted toward slot 0
    always_ff @(posedge i_clk) begin
        if (i_cmd.hdr_wr) begin
            r_store[r_hdr_cnt] <= i_byte;
        end else if (i_cmd.rp_step || i_cmd.emit) begin
            for (int k = 0; k < HDR_BYTES - 1; k++) begin
                r_store[k] <= r_store[k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt  <= '0;
            r_step     <= '0;
            r_rem      <= '0;
            r_hdr_only <= 1'b0;
        end else begin
            if (i_cmd.hdr_clr) begin
                r_hdr_cnt <= '0;
            end else if (i_cmd.hdr_done) begin
                r_hdr_cnt <= '0;
            end else if (i_cmd.hdr_wr) begin
                r_hdr_cnt <= r_hdr_cnt + CNT_W'(1);
            end else if (i_cmd.rp_step && o_sts.rp_match) begin
                // words behind the matching magic become the new header start
                r_hdr_cnt <= r_step - CNT_W'(1);
            end

            if (i_cmd.hdr_done) begin
                r_step     <= CNT_W'(HDR_BYTES);
                r_hdr_only <= (w_len == LEN_W'(FRAME_HDR_SIZE));
                r_rem      <= o_sts.len_short ? '0 : w_len - LEN_W'(FRAME_HDR_SIZE);
            end else if (i_cmd.rp_step || i_cmd.emit) begin
                r_step <= r_step - CNT_W'(1);
            end else if (i_cmd.cont_out) begin
                r_rem <= r_rem - LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.cont_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte     <= r_store[0];
            r_out_first    <= (r_step == CNT_W'(HDR_BYTES));
            r_out_last     <= o_sts.step_last && r_hdr_only;
            r_out_run_last <= o_sts.step_last;
        end else if (i_cmd.cont_out) begin
            r_out_byte     <= i_byte;
            r_out_first    <= 1'b0;
            r_out_last     <= o_sts.rem_one;
            r_out_run_last <= 1'b1;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_out_first    = r_out_first;
    assign o_out_last     = r_out_last;
    assign o_out_run_last = r_out_run_last;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_cnt <= CNT_W'(HDR_BYTES - 1))
        else $error("header count out of range");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.cont_out) |-> w_out_free)
        else $error("output register overwritten");

    a_step_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rp_step || i_cmd.emit) |-> (r_step != '0))
        else $error("step counter underflow");

endmodule

@@ rtl/core/mlfp_ctrl.sv @@
module mlfp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  mlfp_pkg::t_sts   i_sts,
    output mlfp_pkg::t_cmd   o_cmd
);
    import mlfp_pkg::*;

    localparam logic [2:0] S_HUNT    = 3'd0;
    localparam logic [2:0] S_HEADER  = 3'd1;
    localparam logic [2:0] S_REPLAY  = 3'd2;
    localparam logic [2:0] S_EMIT    = 3'd3;
    localparam logic [2:0] S_CONTENT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_HUNT: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid && i_sts.magic_hit) begin
                    o_cmd.hdr_clr = 1'b1;
                    n_state       = S_HEADER;
                end
            end
            S_HEADER: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.hdr_wr = 1'b1;
                    if (i_sts.hdr_full) begin
                        o_cmd.hdr_done = 1'b1;
                        n_state        = i_sts.len_short ? S_REPLAY : S_EMIT;
                    end
                end
            end
            S_REPLAY: begin
                // bad length: look for a new magic in the stored header words
                o_cmd.rp_step = 1'b1;
                if (i_sts.rp_match) begin
                    n_state = S_HEADER;
                end else if (i_sts.step_last) begin
                    n_state = S_HUNT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.step_last) begin
                        n_state = i_sts.hdr_only ? S_HUNT : S_CONTENT;
                    end
                end
            end
            S_CONTENT: begin
                o_s_tready = i_sts.out_free;
                if (i_s_tvalid && i_sts.out_free) begin
                    if (i_sts.rem_zero) begin
                        n_state = S_HUNT;
                    end else begin
                        o_cmd.cont_out = 1'b1;
                        if (i_sts.rem_one) begin
                            n_state = S_HUNT;
                        end
                    end
                end
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    a_replay_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REPLAY && !i_sts.rp_match && !i_sts.step_last) |=>
        (r_state == S_REPLAY))
        else $error("replay left early");

    a_emit_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && i_sts.out_free && i_sts.step_last) |=>
        (r_state == S_HUNT || r_state == S_CONTENT))
        else $error("header release did not finish");

    a_content_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.cont_out && i_sts.rem_one) |=> (r_state == S_HUNT))
        else $error("frame did not end after last content word");

endmodule

@@ rtl/core/magic_length_frame_parser_top.sv @@
// Byte-stream deframer. Each input word is one received byte; the block hunts for the magic
// byte set through the config channel, then collects type, status, error and a big-endian
// 16-bit total length (magic included). A good header releases its five bytes on the master
// side, one word per cycle while the output is free, tuser[0] marking the frame start; then each
// content byte is passed through as it arrives, tlast on the final byte of the frame and tuser[1]
// on the last word caused by one input byte. The leading magic byte is never forwarded, though a
// content byte equal to the magic is. The header release holds the input, one output word at a
// time from the single output register. A length below six starts a replay over the stored
// header bytes, one byte per cycle, with the input held.
module magic_length_frame_parser_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [mlfp_pkg::BYTE_W-1:0]  i_cfg_data,   // magic_value
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [mlfp_pkg::BYTE_W-1:0]  i_s_tdata,    // in_byte
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [mlfp_pkg::BYTE_W-1:0]  o_m_tdata,    // out_byte
    output logic                         o_m_tlast,
    output logic [1:0]                   o_m_tuser     // frame_first, run_last
);
    import mlfp_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_first;
    logic w_run_last;

    assign o_cfg_ready = 1'b1;

    mlfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mlfp_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_byte         (i_s_tdata),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_out_valid    (o_m_tvalid),
        .i_out_ready    (i_m_tready),
        .o_out_byte     (o_m_tdata),
        .o_out_first    (w_first),
        .o_out_last     (o_m_tlast),
        .o_out_run_last (w_run_last)
    );

    assign o_m_tuser = {w_run_last, w_first};

endmodule

@@ bench/magic_length_frame_parser_top_tb.sv @@
`timescale 1ns / 100ps

module magic_length_frame_parser_top_tb;

    import mlfp_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 120;
    localparam int N_DIRECTED   = 23;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEADER,
        PH_CONTENT
    } parse_phase_e;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              first;
        logic              last;
        logic              run_last;
    } frame_word_t;

    // one input byte; typed rows carry their own expectation: either nothing,
    // or the byte passed through as content with the given frame end mark
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              typed;
        logic [2:0]        n;
        logic              last;
    } stim_row_t;

    // directed run, magic set to 8'hA5
    localparam stim_row_t DIRECTED[N_DIRECTED] = '{
        '{8'h00, 1'b1, 3'd0, 1'b0},  // not the magic, stays hunting
        '{8'hA5, 1'b1, 3'd0, 1'b0},
        '{8'h01, 1'b1, 3'd0, 1'b0},
        '{8'h02, 1'b1, 3'd0, 1'b0},
        '{8'h03, 1'b1, 3'd0, 1'b0},
        '{8'h00, 1'b1, 3'd0, 1'b0},
        '{8'h03, 1'b1, 3'd0, 1'b0},  // length 3, no magic in the header, back to hunt
        '{8'hA5, 1'b1, 3'd0, 1'b0},
        '{8'hA5, 1'b1, 3'd0, 1'b0},  // magic as type byte
        '{8'h01, 1'b1, 3'd0, 1'b0},
        '{8'h02, 1'b1, 3'd0, 1'b0},
        '{8'h00, 1'b1, 3'd0, 1'b0},
        '{8'h00, 1'b1, 3'd0, 1'b0},  // length 0, resync from the stored type byte
        '{8'h06, 1'b0, 3'd0, 1'b0},  // completes a header-only frame
        '{8'hA5, 1'b1, 3'd0, 1'b0},
        '{8'hFF, 1'b1, 3'd0, 1'b0},
        '{8'h00, 1'b1, 3'd0, 1'b0},
        '{8'hFF, 1'b1, 3'd0, 1'b0},
        '{8'h00, 1'b1, 3'd0, 1'b0},
        '{8'h08, 1'b0, 3'd0, 1'b0},  // length 8, header released
        '{8'hA5, 1'b1, 3'd1, 1'b0},  // magic inside content is plain data
        '{8'h00, 1'b1, 3'd1, 1'b1},
        '{8'hFF, 1'b1, 3'd0, 1'b0}
    };

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [BYTE_W-1:0] i_cfg_data  = '0;
    logic              i_s_tvalid  = 1'b0;
    logic              o_s_tready;
    logic [BYTE_W-1:0] i_s_tdata   = '0;
    logic              o_m_tvalid;
    logic              i_m_tready  = 1'b0;
    logic [BYTE_W-1:0] o_m_tdata;
    logic              o_m_tlast;
    logic [1:0]        o_m_tuser;   // frame_first, run_last

    magic_length_frame_parser_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // deframer state mirror
    logic [BYTE_W-1:0] magic;
    parse_phase_e      phase;
    logic [BYTE_W-1:0] hdr_store [HDR_BYTES];
    logic [CNT_W-1:0]  hdr_count;
    logic [LEN_W-1:0]  frame_len;
    logic [LEN_W-1:0]  remaining;
    frame_word_t       released [HDR_BYTES];

    frame_word_t pending_words [$];
    stim_row_t   sent_bytes [$];

    int mismatches   = 0;
    int stall_cycles = 0;
    int sent_items   = 0;
    int s_idle_pct   = 6;
    int m_idle_pct   = 72;

    initial begin
        magic     = '0;
        phase     = PH_HUNT;
        hdr_count = '0;
        frame_len = '0;
        remaining = '0;
        for (int i = 0; i < HDR_BYTES; i++) begin
            hdr_store[i] = '0;
        end
    end

    // advances the mirror by one received byte, returns the number of words released
    function automatic int deframe_byte(input logic [BYTE_W-1:0] b);
        int  n;
        int  k;
        int  j;
        logic found;
        n = 0;
        case (phase)
            PH_HEADER: begin
                if (hdr_count >= HDR_BYTES) begin
                    hdr_count = '0;
                end
                hdr_store[hdr_count] = b;
                hdr_count++;
                if (hdr_count == HDR_BYTES) begin
                    frame_len = {hdr_store[3], hdr_store[4]};
                    hdr_count = '0;
                    if (frame_len < FRAME_HDR_SIZE) begin
                        // resync: bytes after the first stored magic start a new header
                        found = 1'b0;
                        for (k = 0; k < HDR_BYTES; k++) begin
                            if (!found && hdr_store[k] == magic) begin
                                found = 1'b1;
                                for (j = k + 1; j < HDR_BYTES; j++) begin
                                    hdr_store[hdr_count] = hdr_store[j];
                                    hdr_count++;
                                end
                            end
                        end
                        phase = found ? PH_HEADER : PH_HUNT;
                    end else begin
                        for (k = 0; k < HDR_BYTES; k++) begin
                            released[k] = '{data: hdr_store[k], first: (k == 0),
                                            last: (k == HDR_BYTES - 1)
                                                  && (frame_len == FRAME_HDR_SIZE),
                                            run_last: (k == HDR_BYTES - 1)};
                        end
                        n = HDR_BYTES;
                        if (frame_len == FRAME_HDR_SIZE) begin
                            remaining = '0;
                            phase = PH_HUNT;
                        end else begin
                            remaining = LEN_W'(frame_len - FRAME_HDR_SIZE);
                            phase = PH_CONTENT;
                        end
                    end
                end
            end
            PH_CONTENT: begin
                if (remaining == 0) begin
                    phase = PH_HUNT;
                end else begin
                    remaining--;
                    released[0] = '{data: b, first: 1'b0, last: (remaining == 0),
                                    run_last: 1'b1};
                    n = 1;
                    if (remaining == 0) begin
                        phase = PH_HUNT;
                    end
                end
            end
            default: begin
                phase = PH_HUNT;
                if (b == magic) begin
                    hdr_count = '0;
                    phase = PH_HEADER;
                end
            end
        endcase
        return n;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // all bookkeeping happens at the rising edge, inputs before outputs
    always @(posedge i_clk) begin : monitor
        int          n;
        int          k;
        logic        busy;
        stim_row_t   row;
        frame_word_t want;
        if (i_rst_n) begin
            busy = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                magic = i_cfg_data;
                busy = 1'b1;
            end
            if (i_s_tvalid && o_s_tready) begin
                row = sent_bytes.pop_front();
                n = deframe_byte(i_s_tdata);
                if (row.typed) begin
                    if (row.n != 0) begin
                        pending_words.push_back('{data: row.value, first: 1'b0,
                                                  last: row.last, run_last: 1'b1});
                    end
                end else begin
                    for (k = 0; k < n; k++) begin
                        pending_words.push_back(released[k]);
                    end
                end
                busy = 1'b1;
            end
            if (o_m_tvalid && i_m_tready) begin
                busy = 1'b1;
                if (pending_words.size() == 0) begin
                    report_mismatch("unexpected word", o_m_tdata, 0);
                end else begin
                    want = pending_words.pop_front();
                    if (o_m_tdata !== want.data)
                        report_mismatch("out_byte", o_m_tdata, want.data);
                    if (o_m_tuser[0] !== want.first)
                        report_mismatch("frame_first", o_m_tuser[0], want.first);
                    if (o_m_tlast !== want.last)
                        report_mismatch("frame_last", o_m_tlast, want.last);
                    if (o_m_tuser[1] !== want.run_last)
                        report_mismatch("run_last", o_m_tuser[1], want.run_last);
                end
            end
            if (busy) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= m_idle_pct);
    end

    // all driving tasks are entered and left at a falling edge
    task automatic write_magic(input logic [BYTE_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_row(input stim_row_t row);
        sent_bytes.push_back(row);
        while ($urandom_range(99) < s_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= row.value;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        send_row('{value: b, typed: 1'b0, n: 3'd0, last: 1'b0});
        sent_items++;
    endtask

    // header byte that is sometimes the magic, to feed the resync path
    function automatic logic [BYTE_W-1:0] header_byte(input int magic_pct);
        return ($urandom_range(99) < magic_pct) ? magic : BYTE_W'($urandom_range(255));
    endfunction

    task automatic send_random_frame();
        int               kind;
        int               len;
        int               i;
        logic [BYTE_W-1:0] b;
        // line noise between frames, ignored while hunting unless it hits the magic
        repeat ($urandom_range(0, 3)) begin
            sent_bytes.push_back('{value: 8'h00, typed: 1'b0, n: 3'd0, last: 1'b0});
            b = BYTE_W'($urandom_range(255));
            sent_bytes.pop_back();
            send_row('{value: b, typed: 1'b0, n: 3'd0, last: 1'b0});
        end
        kind = $urandom_range(99);
        send_byte(magic);
        if (kind < 12) begin
            // short length, triggers the resync replay
            repeat (3) send_byte(header_byte(35));
            send_byte(8'h00);
            send_byte(BYTE_W'($urandom_range(0, FRAME_HDR_SIZE - 1)));
        end else if (kind < 18) begin
            // truncated header, later bytes complete it
            repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(255)));
        end else begin
            len = FRAME_HDR_SIZE + (($urandom_range(9) != 0) ? $urandom_range(0, 10)
                                                             : $urandom_range(11, 40));
            repeat (3) send_byte(header_byte(15));
            send_byte(BYTE_W'(len >> 8));
            send_byte(BYTE_W'(len));
            for (i = FRAME_HDR_SIZE; i < len; i++) begin
                send_byte(header_byte(15));
            end
        end
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sent_bytes.size() != 0 || pending_words.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [BYTE_W-1:0] value, input int s_pct, input int m_pct);
        int target;
        wait_drained();
        write_magic(value);
        s_idle_pct = s_pct;
        m_idle_pct = m_pct;
        target = sent_items + PHASE_ITEMS;
        while (sent_items < target) begin
            send_random_frame();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_magic(8'hA5);
        for (int r = 0; r < N_DIRECTED; r++) begin
            send_row(DIRECTED[r]);
        end

        run_phase(8'h00, 6, 72);
        run_phase(8'hFF, 72, 6);
        run_phase(BYTE_W'($urandom_range(1, 254)), 0, 0);

        // longest length; content keeps flowing without reaching the frame end
        send_byte(magic);
        repeat (3) send_byte(BYTE_W'($urandom_range(255)));
        send_byte(8'hFF);
        send_byte(8'hFF);
        repeat (20) send_byte(header_byte(20));

        wait_drained();
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
